>>> rtl/lru_tile_tag_cache_unit_assert.svh
// assertion macros shared by the tile tag cache rtl
`ifndef LRU_TILE_TAG_CACHE_UNIT_ASSERT_SVH
`define LRU_TILE_TAG_CACHE_UNIT_ASSERT_SVH

// condition holds at every edge outside reset
`define LTTC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LTTC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LTTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/lttc_pkg.sv
package lttc_pkg;

   localparam int ZOOM_W = 5;
   localparam int COL_W  = 24;
   localparam int ROW_W  = 24;
   localparam int KEY_W  = ZOOM_W + COL_W + ROW_W;
   localparam int SLOT_W = 3;

   typedef enum logic [0:0] {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef logic [KEY_W-1:0] key_type;

endpackage

>>> rtl/lttc_if.sv
interface lttc_req_if;
   logic                            valid;
   logic                            ready;
   lttc_pkg::op_type                op;
   logic        [lttc_pkg::ZOOM_W-1:0] zoom_level;
   logic signed [lttc_pkg::COL_W-1:0]  tile_col;
   logic signed [lttc_pkg::ROW_W-1:0]  tile_row;

   modport source (output valid, op, zoom_level, tile_col, tile_row, input ready);
   modport sink   (input valid, op, zoom_level, tile_col, tile_row, output ready);
endinterface

interface lttc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [lttc_pkg::SLOT_W-1:0] slot;
   logic                        evicted;

   modport source (output valid, hit, slot, evicted, input ready);
   modport sink   (input valid, hit, slot, evicted, output ready);
endinterface

>>> rtl/lru_tile_tag_cache_unit.sv
// a request passes through the input register, then the result register, before its result is valid
// one request per cycle while the result is not stalled; the tag compare and rank update are combinational
// a stalled result holds the input register, which frees once the result is taken
// reset (synchronous, active high) clears all valid bits and the fill count at once
// and loads each recency rank with its slot index; no clearing pass is needed
`include "lru_tile_tag_cache_unit_assert.svh"

module lru_tile_tag_cache_unit #(
   parameter int N_ENTRIES = 8
) (
   input  logic       clock,
   input  logic       reset,
   lttc_req_if.sink   req_bus,
   lttc_rsp_if.source rsp_bus
);

   localparam int IDX_W = $clog2(N_ENTRIES);
   localparam int CNT_W = $clog2(N_ENTRIES + 1);

   // input register
   logic               in_valid_ff;
   lttc_pkg::op_type   in_op_ff;
   lttc_pkg::key_type  in_key_ff;

   // tag store
   logic               valid_ff [N_ENTRIES];
   lttc_pkg::key_type  key_ff   [N_ENTRIES];
   logic [IDX_W-1:0]   rank_ff  [N_ENTRIES];
   logic [CNT_W-1:0]   filled_ff;

   // result register
   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   logic [lttc_pkg::SLOT_W-1:0] rsp_slot_ff;
   logic                        rsp_evicted_ff;

   logic advance;
   logic step;

   logic [N_ENTRIES-1:0] match;
   logic                 hit_found;
   logic [IDX_W-1:0]     hit_idx;
   logic [IDX_W-1:0]     lru_idx;
   logic                 full;
   logic                 is_insert;
   logic [IDX_W-1:0]     ins_idx;
   logic [IDX_W-1:0]     sel_idx;
   logic                 touch_en;
   logic [IDX_W-1:0]     old_rank;
   logic                 ins_was_valid;
   logic [IDX_W-1:0]     rank_in [N_ENTRIES];
   logic [CNT_W-1:0]     filled_in;
   logic                 evicted_in;
   logic [IDX_W+2:0]     slot_wide;

   assign advance     = !rsp_valid_ff || rsp_bus.ready;
   assign step        = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.hit     = rsp_hit_ff;
   assign rsp_bus.slot    = rsp_slot_ff;
   assign rsp_bus.evicted = rsp_evicted_ff;

   always_comb begin
      is_insert = (in_op_ff == lttc_pkg::OP_INSERT);
      full      = (filled_ff == CNT_W'(N_ENTRIES));

      // lowest matching slot wins, lru slot holds the oldest rank
      hit_found = 1'b0;
      hit_idx   = '0;
      lru_idx   = '0;
      for (int i = N_ENTRIES - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (key_ff[i] == in_key_ff);
         if (match[i]) begin
            hit_found = 1'b1;
            hit_idx   = IDX_W'(i);
         end
         if (rank_ff[i] == IDX_W'(N_ENTRIES - 1)) begin
            lru_idx = IDX_W'(i);
         end
      end

      ins_idx  = full ? lru_idx : filled_ff[IDX_W-1:0];
      sel_idx  = is_insert ? ins_idx : hit_idx;
      touch_en = is_insert || hit_found;

      old_rank      = '0;
      ins_was_valid = 1'b0;
      for (int i = 0; i < N_ENTRIES; i++) begin
         if (sel_idx == IDX_W'(i)) begin
            old_rank      = old_rank | rank_ff[i];
            ins_was_valid = ins_was_valid | valid_ff[i];
         end
      end

      // touched slot goes to rank zero, younger slots age by one
      for (int i = 0; i < N_ENTRIES; i++) begin
         if (!touch_en) begin
            rank_in[i] = rank_ff[i];
         end else if (sel_idx == IDX_W'(i)) begin
            rank_in[i] = '0;
         end else if (rank_ff[i] < old_rank) begin
            rank_in[i] = rank_ff[i] + IDX_W'(1);
         end else begin
            rank_in[i] = rank_ff[i];
         end
      end

      filled_in  = (is_insert && !full) ? filled_ff + CNT_W'(1) : filled_ff;
      evicted_in = is_insert && full && ins_was_valid;
      slot_wide  = (IDX_W+3)'(sel_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         filled_ff    <= '0;
         for (int i = 0; i < N_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= IDX_W'(i);
         end
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
            filled_ff    <= filled_in;
            for (int i = 0; i < N_ENTRIES; i++) begin
               rank_ff[i] <= rank_in[i];
            end
            if (is_insert) begin
               valid_ff[ins_idx] <= 1'b1;
            end
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_op_ff  <= req_bus.op;
         in_key_ff <= {req_bus.zoom_level, req_bus.tile_col, req_bus.tile_row};
      end
      if (step) begin
         rsp_hit_ff     <= !is_insert && hit_found;
         rsp_slot_ff    <= slot_wide[lttc_pkg::SLOT_W-1:0];
         rsp_evicted_ff <= evicted_in;
         if (is_insert) begin
            key_ff[ins_idx] <= in_key_ff;
         end
      end
   end

   logic [N_ENTRIES-1:0] rank_mru;
   logic [N_ENTRIES-1:0] rank_lru;

   always_comb begin
      for (int i = 0; i < N_ENTRIES; i++) begin
         rank_mru[i] = (rank_ff[i] == '0);
         rank_lru[i] = (rank_ff[i] == IDX_W'(N_ENTRIES - 1));
      end
   end

   `LTTC_ASSERT_ALWAYS(a_one_mru, clock, reset, $onehot(rank_mru), "ranks lost their permutation")
   `LTTC_ASSERT_ALWAYS(a_one_lru, clock, reset, $onehot(rank_lru), "no unique lru slot")
   `LTTC_ASSERT_ALWAYS(a_fill_bound, clock, reset, filled_ff <= CNT_W'(N_ENTRIES),
      "fill count past capacity")
   `LTTC_ASSERT_SAME(a_evict_no_hit, clock, reset, rsp_valid_ff && rsp_evicted_ff, !rsp_hit_ff,
      "result flags both hit and eviction")
   `LTTC_ASSERT_NEXT(a_stall_hold, clock, reset, in_valid_ff && !advance, in_valid_ff,
      "input register dropped a stalled request")

endmodule

>>> sim/tb_lru_tile_tag_cache_unit.sv
`timescale 1ns / 1ps

module tb_lru_tile_tag_cache_unit;

   localparam int NUM_SLOTS    = 8;
   localparam int POOL_SIZE    = 12;
   localparam int RANDOM_ITEMS = 700;
   localparam int BURST_FIRST  = 290;
   localparam int BURST_LAST   = 380;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 80;

   typedef struct packed {
      logic                        hit;
      logic [lttc_pkg::SLOT_W-1:0] slot;
      logic                        evicted;
   } tag_result_type;

   typedef struct {
      lttc_pkg::op_type  op;
      lttc_pkg::key_type key;
      bit                fixed;
      tag_result_type    want;
   } tile_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lttc_req_if req_ch ();
   lttc_rsp_if rsp_ch ();

   lru_tile_tag_cache_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the tag store
   bit                line_valid [NUM_SLOTS];
   lttc_pkg::key_type line_key   [NUM_SLOTS];
   int unsigned       line_age   [NUM_SLOTS];
   int unsigned       lines_filled;

   tag_result_type    pending_results[$];
   tile_req_type      directed_rows[$];
   lttc_pkg::key_type tile_pool[POOL_SIZE];
   bit                insert_follows;
   lttc_pkg::key_type missed_key;

   int mismatches;
   int requests_accepted;
   int results_seen;
   int lookup_hits, lookup_misses, inserts, evictions;

   function automatic int find_line(lttc_pkg::key_type key);
      for (int i = 0; i < NUM_SLOTS; i++)
         if (line_valid[i] && line_key[i] == key) return i;
      return -1;
   endfunction

   function automatic void make_most_recent(int s);
      int unsigned prev;
      prev = line_age[s];
      for (int i = 0; i < NUM_SLOTS; i++)
         if (line_age[i] < prev) line_age[i]++;
      line_age[s] = 0;
   endfunction

   function automatic tag_result_type apply_request(lttc_pkg::op_type op,
                                                    lttc_pkg::key_type key);
      tag_result_type r;
      int             s;
      r = '0;
      if (op == lttc_pkg::OP_LOOKUP) begin
         s = find_line(key);
         if (s >= 0) begin
            r.hit  = 1'b1;
            r.slot = s[lttc_pkg::SLOT_W-1:0];
            make_most_recent(s);
            lookup_hits++;
         end else begin
            lookup_misses++;
         end
      end else begin
         if (lines_filled < NUM_SLOTS) begin
            s = lines_filled;
            lines_filled++;
         end else begin
            // victim is the slot with the oldest age
            s = 0;
            for (int i = 0; i < NUM_SLOTS; i++)
               if (line_age[i] == NUM_SLOTS - 1) s = i;
            r.evicted = line_valid[s];
            if (line_valid[s]) evictions++;
         end
         line_valid[s] = 1'b1;
         line_key[s]   = key;
         make_most_recent(s);
         r.slot = s[lttc_pkg::SLOT_W-1:0];
         inserts++;
      end
      return r;
   endfunction

   function automatic lttc_pkg::key_type random_key();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[lttc_pkg::KEY_W-1:0];
   endfunction

   function automatic void add_row(lttc_pkg::op_type op, int zoom, int col, int row,
                                   bit fixed, bit hit, int slot, bit evicted);
      tile_req_type t;
      t.op           = op;
      t.key          = {zoom[lttc_pkg::ZOOM_W-1:0], col[lttc_pkg::COL_W-1:0],
                        row[lttc_pkg::ROW_W-1:0]};
      t.fixed        = fixed;
      t.want.hit     = hit;
      t.want.slot    = slot[lttc_pkg::SLOT_W-1:0];
      t.want.evicted = evicted;
      directed_rows.push_back(t);
   endfunction

   // mostly lookup-then-fill sequences over a small key pool, plus noise
   function automatic void pick_random_request(output lttc_pkg::op_type op,
                                               output lttc_pkg::key_type key);
      int roll;
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0)
         tile_pool[$urandom_range(0, POOL_SIZE - 1)] = random_key();
      if (insert_follows) begin
         op = lttc_pkg::OP_INSERT;
         key = missed_key;
         insert_follows = 1'b0;
      end else if (roll < 70) begin
         op = lttc_pkg::OP_LOOKUP;
         key = tile_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (find_line(key) < 0) begin
            insert_follows = 1'b1;
            missed_key = key;
         end
      end else if (roll < 85) begin
         op = lttc_pkg::OP_LOOKUP;
         key = random_key();
      end else if (roll < 93) begin
         op = lttc_pkg::OP_INSERT;
         key = tile_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
         op = lttc_pkg::OP_INSERT;
         key = random_key();
      end
   endfunction

   initial begin : request_driver
      lttc_pkg::op_type  op;
      lttc_pkg::key_type key;
      tile_req_type      row;
      tag_result_type    predicted;
      int                gap;
      int                n_items;
      lttc_pkg::key_type junk;

      req_ch.valid      = 1'b0;
      req_ch.op         = lttc_pkg::OP_LOOKUP;
      req_ch.zoom_level = '0;
      req_ch.tile_col   = '0;
      req_ch.tile_row   = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         line_valid[i] = 1'b0;
         line_key[i]   = '0;
         line_age[i]   = i;
      end
      lines_filled   = 0;
      insert_follows = 1'b0;
      for (int p = 0; p < POOL_SIZE; p++) tile_pool[p] = random_key();

      add_row(lttc_pkg::OP_LOOKUP,  0,        0,        0, 1, 0, 0, 0); // zero key, empty store
      add_row(lttc_pkg::OP_LOOKUP, 31,       -1,       -1, 1, 0, 0, 0);
      add_row(lttc_pkg::OP_INSERT,  0,        0,        0, 1, 0, 0, 0);
      add_row(lttc_pkg::OP_LOOKUP,  0,        0,        0, 1, 1, 0, 0);
      add_row(lttc_pkg::OP_INSERT, 31,  8388607, -8388608, 1, 0, 1, 0);
      add_row(lttc_pkg::OP_INSERT, 31,       -1,       -1, 1, 0, 2, 0);
      add_row(lttc_pkg::OP_INSERT, 31,       -1,       -1, 1, 0, 3, 0); // duplicate key
      add_row(lttc_pkg::OP_LOOKUP, 31,       -1,       -1, 1, 1, 2, 0); // lowest copy wins
      add_row(lttc_pkg::OP_LOOKUP, 31,  8388607,        0, 0, 0, 0, 0);
      add_row(lttc_pkg::OP_LOOKUP, 30,  8388607, -8388608, 0, 0, 0, 0);
      add_row(lttc_pkg::OP_INSERT,  0, -8388608,  8388607, 1, 0, 4, 0);
      add_row(lttc_pkg::OP_INSERT, 15,    12345,   -12345, 1, 0, 5, 0);
      add_row(lttc_pkg::OP_INSERT, 16,       -2,        2, 1, 0, 6, 0);
      add_row(lttc_pkg::OP_INSERT,  7, 'h2AAAAA, 'h555555, 1, 0, 7, 0);
      add_row(lttc_pkg::OP_LOOKUP, 31,  8388607, -8388608, 1, 1, 1, 0);
      add_row(lttc_pkg::OP_LOOKUP,  0, -8388608,  8388607, 0, 0, 0, 0);
      add_row(lttc_pkg::OP_INSERT,  8,      100,     -100, 0, 0, 0, 0); // store full, evicts
      add_row(lttc_pkg::OP_INSERT,  9,     -100,      100, 0, 0, 0, 0);
      add_row(lttc_pkg::OP_LOOKUP,  0,        0,        0, 0, 0, 0, 0);
      add_row(lttc_pkg::OP_LOOKUP,  8,      100,     -100, 0, 0, 0, 0);
      add_row(lttc_pkg::OP_INSERT,  1,        1,        1, 0, 0, 0, 0);
      add_row(lttc_pkg::OP_INSERT,  2,        2,        2, 0, 0, 0, 0);
      add_row(lttc_pkg::OP_LOOKUP, 31,       -1,       -1, 0, 0, 0, 0);
      add_row(lttc_pkg::OP_LOOKUP,  7, 'h2AAAAA, 'h555555, 0, 0, 0, 0);

      wait (reset == 1'b0);
      @(negedge clock);
      n_items = directed_rows.size() + RANDOM_ITEMS;
      for (int i = 0; i < n_items; i++) begin
         if (i < directed_rows.size()) begin
            row = directed_rows[i];
         end else begin
            pick_random_request(op, key);
            row.op    = op;
            row.key   = key;
            row.fixed = 1'b0;
            row.want  = '0;
         end

         if (i >= BURST_FIRST && i < BURST_LAST) gap = 0;
         else if ((i / 40) % 4 == 3) gap = 0;
         else gap = $urandom_range(0, 17);

         if (gap > 0) begin
            junk = random_key();
            req_ch.valid      <= 1'b0;
            req_ch.op         <= lttc_pkg::op_type'($urandom_range(0, 1));
            req_ch.zoom_level <= junk[lttc_pkg::KEY_W-1 -: lttc_pkg::ZOOM_W];
            req_ch.tile_col   <= junk[lttc_pkg::COL_W+lttc_pkg::ROW_W-1 -: lttc_pkg::COL_W];
            req_ch.tile_row   <= junk[lttc_pkg::ROW_W-1:0];
            repeat (gap) @(negedge clock);
         end
         req_ch.valid      <= 1'b1;
         req_ch.op         <= row.op;
         req_ch.zoom_level <= row.key[lttc_pkg::KEY_W-1 -: lttc_pkg::ZOOM_W];
         req_ch.tile_col   <= row.key[lttc_pkg::COL_W+lttc_pkg::ROW_W-1 -: lttc_pkg::COL_W];
         req_ch.tile_row   <= row.key[lttc_pkg::ROW_W-1:0];

         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         predicted = apply_request(row.op, row.key);
         pending_results.push_back(row.fixed ? row.want : predicted);
         requests_accepted++;
         @(negedge clock);
      end
      req_ch.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d requests (%0d directed): %0d lookup hits, %0d lookup misses",
               requests_accepted, directed_rows.size(), lookup_hits, lookup_misses);
      $display("%0d inserts with %0d evictions of valid lines, %0d results checked",
               inserts, evictions, results_seen);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : result_receiver
      int stall;
      bit held;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         // one long hold while the sender keeps streaming, to back up the pipe
         if (!held && requests_accepted >= HOLD_AT) begin
            stall = HOLD_CYCLES;
            held  = 1'b1;
         end else if ((results_seen / 40) % 4 == 1) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 17);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      tag_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result with no request outstanding: hit %0d slot %0d evicted %0d",
                   rsp_ch.hit, rsp_ch.slot, rsp_ch.evicted);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.hit !== want.hit) begin
               $error("hit: expected %0d actual %0d", want.hit, rsp_ch.hit);
               mismatches++;
            end
            if (rsp_ch.slot !== want.slot) begin
               $error("slot: expected %0d actual %0d", want.slot, rsp_ch.slot);
               mismatches++;
            end
            if (rsp_ch.evicted !== want.evicted) begin
               $error("evicted: expected %0d actual %0d", want.evicted, rsp_ch.evicted);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #500000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/lttc_pkg.sv
rtl/lttc_if.sv
rtl/lru_tile_tag_cache_unit.sv
sim/tb_lru_tile_tag_cache_unit.sv
